/* sv/ssmd_pkg.sv */
// Shared types and constants for the single-source max delay block.
// No dependencies; imported by single_source_max_delay.
`default_nettype none

package ssmd_pkg;

  localparam int LABEL_W    = 8;
  localparam int WEIGHT_IN_W = 16;
  localparam int DIST_W     = 23;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NODE_COUNT  = 1'b0,
    REG_SOURCE_NODE = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_EDGE_RD,
    S_DIST_RD,
    S_RELAX,
    S_PASS_END,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] cost;
  } dist_word_t;

endpackage

`default_nettype wire

/* sv/single_source_max_delay.sv */
// Single-source max delay: edge store loader and Bellman-Ford relaxation engine.
// Depends on ssmd_pkg (state enum, register codes, distance word type).
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------------------
//  in      | input     | in_valid_i / in_ready_o    | has_edge, edge_from, edge_to,
//          |           |                            | edge_weight, last_edge
//  out     | output    | out_valid_o / out_ready_i  | max_delay, unreachable, edge_overflow
//  cfg     | input     | cfg_valid_i / cfg_ready_o  | cfg_index, cfg_data
//
// Edge items are stored as they are accepted. An item with last_edge starts a run: the clear
// state writes all n distance words (n = effective node count), each pass walks the E
// stored edges (edge read, two-port distance read, relax and write back), passes repeat
// until one changes nothing, then a scan reads each distance word to form the result. No
// item is taken during a run. Reset clears control state only; the memories need no
// clearing pass. A finished result waits in the output register while new edge items load.
`default_nettype none

module single_source_max_delay
  import ssmd_pkg::*;
#(
  parameter int MAX_NODES   = 128,
  parameter int MAX_EDGES   = 8192,
  parameter int WEIGHT_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic                   has_edge_i,
  input  wire logic [LABEL_W-1:0]     edge_from_i,
  input  wire logic [LABEL_W-1:0]     edge_to_i,
  input  wire logic [WEIGHT_IN_W-1:0] edge_weight_i,
  input  wire logic                   last_edge_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [DIST_W-1:0]           max_delay_o,
  output logic                        unreachable_o,
  output logic                        edge_overflow_o,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int IW   = $clog2(MAX_NODES);
  localparam int CW   = $clog2(MAX_NODES + 1);
  localparam int CMPW = (CW > LABEL_W) ? CW : LABEL_W;
  localparam int EW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int FW   = $clog2(MAX_EDGES + 1);
  localparam int WSW  = (WEIGHT_BITS < WEIGHT_IN_W) ? WEIGHT_BITS : WEIGHT_IN_W;

  typedef struct packed {
    logic [LABEL_W-1:0] from;
    logic [LABEL_W-1:0] to;
    logic [WSW-1:0]     weight;
  } edge_t;

  state_e state_q, state_d;

  logic [CFG_DATA_W-1:0] node_count_q, node_count_d;
  logic [CFG_DATA_W-1:0] source_node_q, source_node_d;
  logic [FW-1:0]         fill_q, fill_d;
  logic                  ovf_q, ovf_d;
  logic                  changed_q, changed_d;
  logic [CW-1:0]         n_q, n_d;
  logic [IW-1:0]         cidx_q, cidx_d;
  logic [EW-1:0]         eidx_q, eidx_d;
  logic                  out_valid_q, out_valid_d;
  logic                  missing_q, missing_d;
  logic [DIST_W-1:0]     best_q, best_d;
  logic [DIST_W-1:0]     max_delay_q, max_delay_d;
  logic                  unreach_q, unreach_d;
  logic                  out_ovf_q, out_ovf_d;

  edge_t      edge_mem [MAX_EDGES];
  edge_t      edge_rd_q;
  logic       edge_we, edge_re;
  edge_t      edge_wdata;

  dist_word_t dist_mem [MAX_NODES];
  dist_word_t da_q, db_q;
  logic       dist_we, dist_re;
  logic [IW-1:0] dist_waddr, da_addr, db_addr;
  dist_word_t dist_wdata;

  logic              in_acc;
  logic              src_ok;
  logic [IW-1:0]     src_idx;
  logic              from_ok, to_ok, edge_ok;
  logic [IW-1:0]     a_idx, b_idx;
  logic [DIST_W:0]   sum_raw;
  logic [DIST_W-1:0] sum_sat;
  logic              improve;
  logic              cidx_last, eidx_last;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign out_valid_o     = out_valid_q;
  assign max_delay_o     = max_delay_q;
  assign unreachable_o   = unreach_q;
  assign edge_overflow_o = out_ovf_q;

  assign src_ok  = (source_node_q != '0) && (CMPW'(source_node_q) <= CMPW'(n_q));
  assign src_idx = IW'(source_node_q - CFG_DATA_W'(1));

  assign from_ok = (edge_rd_q.from != '0) && (CMPW'(edge_rd_q.from) <= CMPW'(n_q));
  assign to_ok   = (edge_rd_q.to != '0) && (CMPW'(edge_rd_q.to) <= CMPW'(n_q));
  assign edge_ok = from_ok && to_ok;
  assign a_idx   = IW'(edge_rd_q.from - LABEL_W'(1));
  assign b_idx   = IW'(edge_rd_q.to - LABEL_W'(1));

  assign sum_raw = {1'b0, da_q.cost} + (DIST_W + 1)'(edge_rd_q.weight);
  assign sum_sat = sum_raw[DIST_W] ? DIST_MAX : sum_raw[DIST_W-1:0];
  assign improve = edge_ok && da_q.valid && (!db_q.valid || (db_q.cost > sum_sat));

  assign cidx_last = (CW'(cidx_q) == (n_q - CW'(1)));
  assign eidx_last = (FW'(eidx_q) == (fill_q - FW'(1)));

  always_comb begin
    node_count_d  = node_count_q;
    source_node_d = source_node_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_NODE_COUNT:  node_count_d  = cfg_data_i;
        REG_SOURCE_NODE: source_node_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    ovf_d       = ovf_q;
    changed_d   = changed_q;
    n_d         = n_q;
    cidx_d      = cidx_q;
    eidx_d      = eidx_q;
    missing_d   = missing_q;
    best_d      = best_q;
    max_delay_d = max_delay_q;
    unreach_d   = unreach_q;
    out_ovf_d   = out_ovf_q;
    out_valid_d = out_valid_q && !out_ready_i;

    edge_we    = 1'b0;
    edge_re    = 1'b0;
    edge_wdata = '{from: edge_from_i, to: edge_to_i, weight: edge_weight_i[WSW-1:0]};
    dist_we    = 1'b0;
    dist_re    = 1'b0;
    dist_waddr = cidx_q;
    dist_wdata = '{valid: src_ok && (cidx_q == src_idx), cost: '0};
    da_addr    = a_idx;
    db_addr    = b_idx;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (has_edge_i) begin
            if (fill_q < FW'(MAX_EDGES)) begin
              edge_we = 1'b1;
              fill_d  = fill_q + FW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
          if (last_edge_i) begin
            if (node_count_q == '0) begin
              n_d = CW'(1);
            end else if (CMPW'(node_count_q) > CMPW'(MAX_NODES)) begin
              n_d = CW'(MAX_NODES);
            end else begin
              n_d = CW'(node_count_q);
            end
            cidx_d    = '0;
            missing_d = 1'b0;
            best_d    = '0;
            state_d   = S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        dist_we = 1'b1;
        if (cidx_last) begin
          cidx_d    = '0;
          eidx_d    = '0;
          changed_d = 1'b0;
          state_d   = (fill_q == '0) ? S_SCAN_RD : S_EDGE_RD;
        end else begin
          cidx_d = cidx_q + IW'(1);
        end
      end
      S_EDGE_RD: begin
        edge_re = 1'b1;
        state_d = S_DIST_RD;
      end
      S_DIST_RD: begin
        dist_re = 1'b1;
        state_d = S_RELAX;
      end
      S_RELAX: begin
        if (improve) begin
          dist_we    = 1'b1;
          dist_waddr = b_idx;
          dist_wdata = '{valid: 1'b1, cost: sum_sat};
          changed_d  = 1'b1;
        end
        if (eidx_last) begin
          state_d = S_PASS_END;
        end else begin
          eidx_d  = eidx_q + EW'(1);
          state_d = S_EDGE_RD;
        end
      end
      S_PASS_END: begin
        eidx_d    = '0;
        changed_d = 1'b0;
        state_d   = changed_q ? S_EDGE_RD : S_SCAN_RD;
      end
      S_SCAN_RD: begin
        dist_re = 1'b1;
        da_addr = cidx_q;
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (!da_q.valid) begin
          missing_d = 1'b1;
        end else if (da_q.cost > best_q) begin
          best_d = da_q.cost;
        end
        if (cidx_last) begin
          state_d = S_DONE;
        end else begin
          cidx_d  = cidx_q + IW'(1);
          state_d = S_SCAN_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          max_delay_d = missing_q ? '0 : best_q;
          unreach_d   = missing_q;
          out_ovf_d   = ovf_q;
          fill_d      = '0;
          ovf_d       = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q  <= CFG_DATA_W'(1);
      source_node_q <= CFG_DATA_W'(1);
      fill_q        <= '0;
      ovf_q         <= 1'b0;
      changed_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      n_q           <= CW'(1);
      cidx_q        <= '0;
      eidx_q        <= '0;
    end else begin
      node_count_q  <= node_count_d;
      source_node_q <= source_node_d;
      fill_q        <= fill_d;
      ovf_q         <= ovf_d;
      changed_q     <= changed_d;
      out_valid_q   <= out_valid_d;
      n_q           <= n_d;
      cidx_q        <= cidx_d;
      eidx_q        <= eidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    missing_q   <= missing_d;
    best_q      <= best_d;
    max_delay_q <= max_delay_d;
    unreach_q   <= unreach_d;
    out_ovf_q   <= out_ovf_d;
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[fill_q[EW-1:0]] <= edge_wdata;
    end
    if (edge_re) begin
      edge_rd_q <= edge_mem[eidx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    if (dist_re) begin
      da_q <= dist_mem[da_addr];
      db_q <= dist_mem[db_addr];
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(MAX_EDGES))
    else $error("edge fill count above store capacity");

  a_relax_lowers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RELAX && dist_we) |-> (!db_q.valid || (sum_sat < db_q.cost)))
    else $error("relax write does not lower the target distance");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result loaded outside the done state");

  a_unreach_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && unreachable_o) |-> (max_delay_o == '0))
    else $error("unreachable result carries a nonzero delay");

endmodule

`default_nettype wire

/* tb/tb.sv */
// Testbench for single_source_max_delay: edge lists stream in, and each run's max delay,
// unreachable and overflow flags are checked against a Bellman-Ford predictor kept here.
// Depends on ssmd_pkg and single_source_max_delay.
module tb;
  import ssmd_pkg::*;

  localparam int MAX_NODES    = 128;
  localparam int MAX_EDGES    = 8192;
  localparam int WEIGHT_BITS  = 16;
  localparam int IDLE_PCT     = 21;
  localparam int HOLD_CYCLES  = 600;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int RANDOM_ITEMS = 900;
  localparam int PHASE_ITEMS  = 90;
  localparam logic [WEIGHT_IN_W-1:0] WEIGHT_MASK = WEIGHT_IN_W'((1 << WEIGHT_BITS) - 1);

  typedef struct {
    logic                   has_edge;
    logic [LABEL_W-1:0]     src_n;
    logic [LABEL_W-1:0]     dst_n;
    logic [WEIGHT_IN_W-1:0] weight;
    logic                   last_edge;
  } edge_item_t;

  typedef struct {
    logic [DIST_W-1:0] dly;
    logic              unreach;
    logic              spill;
  } delay_result_t;

  typedef struct {
    cfg_reg_e              idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_write_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid    = 1'b0;
  logic                   has_edge    = 1'b0;
  logic [LABEL_W-1:0]     edge_from   = '0;
  logic [LABEL_W-1:0]     edge_to     = '0;
  logic [WEIGHT_IN_W-1:0] edge_weight = '0;
  logic                   last_edge   = 1'b0;
  logic                   out_ready   = 1'b0;
  logic                   cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data    = '0;

  wire                    in_ready;
  wire                    out_valid;
  wire [DIST_W-1:0]       max_delay;
  wire                    unreachable;
  wire                    edge_overflow;
  wire                    cfg_ready;

  edge_item_t    item_q[$];
  cfg_write_t    cfg_q[$];
  delay_result_t delay_q[$];

  int items_queued = 0;
  int items_sent   = 0;
  int cfg_queued   = 0;
  int cfg_done     = 0;
  int stim_items   = 0;
  int errors       = 0;
  int cycles       = 0;
  int idle_pct     = IDLE_PCT;
  int hold_token   = 0;
  int hold_seen    = 0;
  int hold_left    = 0;

  logic          in_taken  = 1'b0;
  logic          cfg_taken = 1'b0;
  edge_item_t    drv_item;
  cfg_write_t    drv_cfg;
  delay_result_t want;

  logic [LABEL_W-1:0]     st_from [MAX_EDGES];
  logic [LABEL_W-1:0]     st_to   [MAX_EDGES];
  logic [WEIGHT_IN_W-1:0] st_wt   [MAX_EDGES];
  int                     fill      = 0;
  logic                   spill     = 1'b0;
  logic [CFG_DATA_W-1:0]  cfg_nodes = 8'd1;
  logic [CFG_DATA_W-1:0]  cfg_src   = 8'd1;

  single_source_max_delay #(
    .MAX_NODES  (MAX_NODES),
    .MAX_EDGES  (MAX_EDGES),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .has_edge_i     (has_edge),
    .edge_from_i    (edge_from),
    .edge_to_i      (edge_to),
    .edge_weight_i  (edge_weight),
    .last_edge_i    (last_edge),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .max_delay_o    (max_delay),
    .unreachable_o  (unreachable),
    .edge_overflow_o(edge_overflow),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  function automatic int eff_of(input int nodes);
    if (nodes == 0) return 1;
    if (nodes > MAX_NODES) return MAX_NODES;
    return nodes;
  endfunction

  function automatic delay_result_t relax_all();
    int unsigned   arrival [MAX_NODES];
    bit            reached [MAX_NODES];
    int unsigned   n, a, b, sum, worst;
    bit            changed, missing;
    int            i;
    delay_result_t res;
    n = eff_of(cfg_nodes);
    worst = 0;
    missing = 1'b0;
    for (i = 0; i < MAX_NODES; i++) begin
      arrival[i] = 0;
      reached[i] = 1'b0;
    end
    if (cfg_src >= 1 && cfg_src <= n) reached[cfg_src - 1] = 1'b1;
    changed = 1'b1;
    while (changed) begin
      changed = 1'b0;
      for (i = 0; i < fill; i++) begin
        a = st_from[i];
        b = st_to[i];
        if (a >= 1 && a <= n && b >= 1 && b <= n && reached[a - 1]) begin
          sum = arrival[a - 1] + st_wt[i];
          if (sum > DIST_MAX) sum = DIST_MAX;
          if (!reached[b - 1] || arrival[b - 1] > sum) begin
            arrival[b - 1] = sum;
            reached[b - 1] = 1'b1;
            changed = 1'b1;
          end
        end
      end
    end
    for (i = 0; i < n; i++) begin
      if (!reached[i]) missing = 1'b1;
      else if (arrival[i] > worst) worst = arrival[i];
    end
    res.dly = missing ? '0 : DIST_W'(worst);
    res.unreach = missing;
    res.spill = spill;
    return res;
  endfunction

  function automatic edge_item_t make_item(input logic has, input logic [LABEL_W-1:0] s,
                                           input logic [LABEL_W-1:0] d,
                                           input logic [WEIGHT_IN_W-1:0] w, input logic last);
    edge_item_t it;
    it.has_edge = has;
    it.src_n = s;
    it.dst_n = d;
    it.weight = w;
    it.last_edge = last;
    return it;
  endfunction

  function automatic logic [LABEL_W-1:0] pick_label(input int n_eff);
    int r;
    r = $urandom_range(0, 19);
    if (r < 17) return LABEL_W'($urandom_range(1, n_eff));
    if (r == 17) return '0;
    if (r == 18 && n_eff < 255) return LABEL_W'($urandom_range(n_eff + 1, 255));
    return LABEL_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [WEIGHT_IN_W-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return WEIGHT_IN_W'($urandom_range(0, 65535));
      5, 6:    return WEIGHT_IN_W'($urandom_range(0, 255));
      default: return WEIGHT_IN_W'($urandom_range(1, 12));
    endcase
  endfunction

  task automatic push_item(input edge_item_t it);
    item_q.push_back(it);
    items_queued++;
    if (it.has_edge || it.last_edge) stim_items++;
  endtask

  task automatic add_list(input int n_eff, input int src, input bit span, input int extra);
    edge_item_t lst[$];
    edge_item_t e;
    int         order[$];
    int         k, j, t;
    if (span && src >= 1 && src <= n_eff) begin
      for (k = 1; k <= n_eff; k++) if (k != src) order.push_back(k);
      for (k = order.size() - 1; k > 0; k--) begin
        j = $urandom_range(0, k);
        t = order[k];
        order[k] = order[j];
        order[j] = t;
      end
      order.push_front(src);
      for (k = 1; k < order.size(); k++)
        lst.push_back(make_item(1'b1, LABEL_W'(order[$urandom_range(0, k - 1)]),
                                LABEL_W'(order[k]), pick_weight(), 1'b0));
    end
    for (k = 0; k < extra; k++)
      lst.push_back(make_item(1'b1, pick_label(n_eff), pick_label(n_eff), pick_weight(), 1'b0));
    for (k = lst.size() - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      e = lst[k];
      lst[k] = lst[j];
      lst[j] = e;
    end
    if (lst.size() != 0 && $urandom_range(0, 1)) begin
      e = lst.pop_back();
      e.last_edge = 1'b1;
      lst.push_back(e);
    end else begin
      lst.push_back(make_item(1'b0, LABEL_W'($urandom_range(0, 255)),
                              LABEL_W'($urandom_range(0, 255)),
                              WEIGHT_IN_W'($urandom_range(0, 65535)), 1'b1));
    end
    for (k = 0; k < lst.size(); k++) begin
      if ($urandom_range(0, 9) == 0)
        push_item(make_item(1'b0, LABEL_W'($urandom_range(0, 255)),
                            LABEL_W'($urandom_range(0, 255)),
                            WEIGHT_IN_W'($urandom_range(0, 65535)), 1'b0));
      push_item(lst[k]);
    end
  endtask

  task automatic write_cfg(input logic [CFG_DATA_W-1:0] nodes, input logic [CFG_DATA_W-1:0] src);
    cfg_write_t w;
    w.idx = REG_NODE_COUNT;
    w.data = nodes;
    cfg_q.push_back(w);
    w.idx = REG_SOURCE_NODE;
    w.data = src;
    cfg_q.push_back(w);
    cfg_queued += 2;
    while (cfg_done != cfg_queued) @(negedge clk_i);
  endtask

  task automatic drain();
    while (items_sent != items_queued || delay_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, delay_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || in_taken) begin
        if (item_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          drv_item = item_q.pop_front();
          in_valid <= 1'b1;
          has_edge <= drv_item.has_edge;
          edge_from <= drv_item.src_n;
          edge_to <= drv_item.dst_n;
          edge_weight <= drv_item.weight;
          last_edge <= drv_item.last_edge;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (!cfg_valid || cfg_taken) begin
        if (cfg_q.size() != 0) begin
          drv_cfg = cfg_q.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= drv_cfg.idx;
          cfg_data <= drv_cfg.data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  always @(posedge clk_i) begin
    in_taken <= in_valid && in_ready;
    cfg_taken <= cfg_valid && cfg_ready;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (delay_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result max_delay=%0d unreachable=%0b edge_overflow=%0b",
                   $time, max_delay, unreachable, edge_overflow);
        end else begin
          want = delay_q.pop_front();
          if (max_delay !== want.dly) begin
            errors++;
            $display("%0t: max_delay expected %0d, got %0d", $time, want.dly, max_delay);
          end
          if (unreachable !== want.unreach) begin
            errors++;
            $display("%0t: unreachable expected %0b, got %0b", $time, want.unreach, unreachable);
          end
          if (edge_overflow !== want.spill) begin
            errors++;
            $display("%0t: edge_overflow expected %0b, got %0b", $time, want.spill,
                     edge_overflow);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_NODE_COUNT) cfg_nodes = cfg_data;
        else cfg_src = cfg_data;
        cfg_done <= cfg_done + 1;
      end
      if (in_valid && in_ready) begin
        if (has_edge) begin
          if (fill < MAX_EDGES) begin
            st_from[fill] = edge_from;
            st_to[fill] = edge_to;
            st_wt[fill] = edge_weight & WEIGHT_MASK;
            fill++;
          end else begin
            spill = 1'b1;
          end
        end
        if (last_edge) begin
          delay_q.push_back(relax_all());
          fill = 0;
          spill = 1'b0;
        end
        items_sent <= items_sent + 1;
      end
    end
  end

  initial begin : stimulus
    int p, nodes, src, n_eff, r, first, k;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset config: empty list, then a self loop
    push_item(make_item(1'b0, 8'd0, 8'd0, 16'd0, 1'b1));
    push_item(make_item(1'b1, 8'd1, 8'd1, 16'hFFFF, 1'b1));
    drain();

    // chain from node 2 with max weights, bad labels and an empty item mixed in
    write_cfg(8'd4, 8'd2);
    push_item(make_item(1'b1, 8'd2, 8'd3, 16'hFFFF, 1'b0));
    push_item(make_item(1'b1, 8'd3, 8'd4, 16'hFFFF, 1'b0));
    push_item(make_item(1'b0, 8'd0, 8'd0, 16'd0, 1'b0));
    push_item(make_item(1'b1, 8'd0, 8'd1, 16'd5, 1'b0));
    push_item(make_item(1'b1, 8'd2, 8'd0, 16'd7, 1'b0));
    push_item(make_item(1'b1, 8'd255, 8'd255, 16'd0, 1'b0));
    push_item(make_item(1'b1, 8'd4, 8'd1, 16'hFFFF, 1'b0));
    push_item(make_item(1'b1, 8'd1, 8'd2, 16'd0, 1'b1));
    drain();

    // node count zero and a bad source
    write_cfg(8'd0, 8'd0);
    push_item(make_item(1'b1, 8'd1, 8'd1, 16'd3, 1'b1));
    drain();

    // node count above the maximum
    write_cfg(8'd255, 8'd128);
    push_item(make_item(1'b1, 8'd128, 8'd1, 16'hFFFF, 1'b0));
    push_item(make_item(1'b1, 8'd128, 8'd128, 16'd1, 1'b0));
    push_item(make_item(1'b0, 8'd255, 8'd255, 16'hFFFF, 1'b1));
    drain();
    write_cfg(8'd128, 8'd200);
    push_item(make_item(1'b0, 8'd0, 8'd0, 16'd0, 1'b1));
    drain();

    first = stim_items;
    for (p = 0; stim_items - first < RANDOM_ITEMS; p++) begin
      r = $urandom_range(0, 9);
      if (p == 1 || p == 2) nodes = $urandom_range(3, 8);
      else if (p == 3) nodes = MAX_NODES;
      else if (p == 4) nodes = $urandom_range(MAX_NODES + 1, 255);
      else if (r == 0) nodes = 0;
      else if (r == 1) nodes = 1;
      else if (r < 6) nodes = $urandom_range(2, 10);
      else if (r < 9) nodes = $urandom_range(11, 24);
      else nodes = $urandom_range(25, MAX_NODES);
      n_eff = eff_of(nodes);
      r = $urandom_range(0, 9);
      if (r == 0) src = 0;
      else if (r == 1 && n_eff < 255) src = $urandom_range(n_eff + 1, 255);
      else src = $urandom_range(1, n_eff);
      if (p == 3) src = $urandom_range(1, MAX_NODES);
      write_cfg(CFG_DATA_W'(nodes), CFG_DATA_W'(src));
      if (p == 1) idle_pct = 0;
      if (p == 3) add_list(n_eff, src, 1'b1, 4);
      k = stim_items;
      while (stim_items - k < PHASE_ITEMS)
        add_list(n_eff, src, n_eff <= 24 && $urandom_range(0, 2) != 0,
                 $urandom_range(0, 3) == 0 ? $urandom_range(0, 30) : $urandom_range(0, 6));
      // stall the result side so runs back up into the input
      if (p == 2) hold_token++;
      drain();
      idle_pct = IDLE_PCT;
    end

    repeat (40) @(negedge clk_i);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
